### hw/rtl/rti_pkg.sv
package rti_pkg;

	// Coordinate and register widths
	localparam int COORD_WIDTH = 32;
	localparam int CW          = COORD_WIDTH;
	localparam int DIR_W       = 18;
	localparam int THR_W       = 40;
	localparam int CFG_W       = (CW > THR_W) ? CW : THR_W;
	localparam int IDX_W       = 3;

	// Derived datapath widths, exact for every input pattern
	localparam int EW    = CW + 1;            // edge and origin offset
	localparam int HP_W  = DIR_W + EW;        // dir * edge product
	localparam int H_W   = HP_W + 1;          // h = dir x e2
	localparam int QP_W  = 2 * EW;            // edge * edge product
	localparam int Q_W   = QP_W + 1;          // q = s x e1
	localparam int HL    = H_W / 2;           // low split of h
	localparam int QL    = Q_W / 2;           // low split of q
	localparam int DOT_W = DIR_W + 2 * EW + 3; // det, un, vn
	localparam int TN_W  = 3 * EW + 3;        // tn

	// Partial product widths
	localparam int DLO_W = EW + HL + 1;
	localparam int DHI_W = EW + H_W - HL;
	localparam int VLO_W = DIR_W + QL + 1;
	localparam int VHI_W = DIR_W + Q_W - QL;
	localparam int TLO_W = EW + QL + 1;
	localparam int THI_W = EW + Q_W - QL;

	localparam int NSTAGE = 8;

	typedef logic signed [CW-1:0]    coord_t;
	typedef logic signed [DIR_W-1:0] dir_t;
	typedef logic        [THR_W-1:0] thr_t;
	typedef logic signed [EW-1:0]    edge_t;
	typedef logic signed [HP_W-1:0]  hprod_t;
	typedef logic signed [H_W-1:0]   h_t;
	typedef logic signed [QP_W-1:0]  qprod_t;
	typedef logic signed [Q_W-1:0]   q_t;
	typedef logic signed [DOT_W-1:0] dot_t;
	typedef logic signed [TN_W-1:0]  tn_t;

	typedef enum logic [IDX_W-1:0] {
		REG_ORIGIN_X      = 3'd0,
		REG_ORIGIN_Y      = 3'd1,
		REG_ORIGIN_Z      = 3'd2,
		REG_DIR_X         = 3'd3,
		REG_DIR_Y         = 3'd4,
		REG_DIR_Z         = 3'd5,
		REG_DET_THRESHOLD = 3'd6
	} cfg_reg_t;

endpackage

### hw/rtl/ray_triangle_intersect.sv
// Ray/triangle hit test, fixed point, eight register stages.
// Throughput: one triangle per cycle unless the output stalls; each stage
// advances on its own; a stall holds only full stages back to the first gap.
// Reset: arst_n clears all valid bits and loads the register reset values
// (origin and direction zero, det_threshold one); datapath is not reset.
module ray_triangle_intersect (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [rti_pkg::IDX_W-1:0]       cfg_index,
	input  logic [rti_pkg::CFG_W-1:0]       cfg_data,
	// triangle beats
	input  logic                            in_valid,
	output logic                            in_ready,
	input  rti_pkg::coord_t                 vertex_a_x,
	input  rti_pkg::coord_t                 vertex_a_y,
	input  rti_pkg::coord_t                 vertex_a_z,
	input  rti_pkg::coord_t                 vertex_b_x,
	input  rti_pkg::coord_t                 vertex_b_y,
	input  rti_pkg::coord_t                 vertex_b_z,
	input  rti_pkg::coord_t                 vertex_c_x,
	input  rti_pkg::coord_t                 vertex_c_y,
	input  rti_pkg::coord_t                 vertex_c_z,
	// result beats
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            hit
);
	import rti_pkg::*;

	// Pipeline map:
	//   s1 edges e1, e2 and origin offset s
	//   s2 cross-product terms for h = d x e2 and q = s x e1
	//   s3 cross-product differences
	//   s4 dot-product partial products (h and q split in halves)
	//   s5 rejoin halves
	//   s6 three-term sums: det, un, vn, tn
	//   s7 sign correction by det
	//   s8 bounds tests; this is also the output register
	// A zero direction gives h = 0 and hence det = 0, which the det test rejects.

	coord_t origin_q [3];
	dir_t   dir_q    [3];
	thr_t   thr_q;

	coord_t va [3];
	coord_t vb [3];
	coord_t vc [3];

	edge_t e1_s1 [3];
	edge_t e2_s1 [3];
	edge_t s_s1  [3];
	edge_t e1_s3 [3];
	edge_t e2_s3 [3];
	edge_t s_s3  [3];
	h_t    h_s3  [3];
	q_t    q_s3  [3];
	dot_t  det_s6;
	dot_t  un_s6;
	dot_t  vn_s6;
	tn_t   tn_s6;
	logic  hit_s8;

	// bit k holds the valid flag of stage k
	logic [NSTAGE:1] vld_q;
	logic [NSTAGE:1] vld_in;
	logic [NSTAGE:1] stage_en;

	// Configuration registers; writes to an unused index drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				origin_q[i] <= '0;
				dir_q[i]    <= '0;
			end
			thr_q <= THR_W'(1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ORIGIN_X:      origin_q[0] <= cfg_data[CW-1:0];
				REG_ORIGIN_Y:      origin_q[1] <= cfg_data[CW-1:0];
				REG_ORIGIN_Z:      origin_q[2] <= cfg_data[CW-1:0];
				REG_DIR_X:         dir_q[0]    <= cfg_data[DIR_W-1:0];
				REG_DIR_Y:         dir_q[1]    <= cfg_data[DIR_W-1:0];
				REG_DIR_Z:         dir_q[2]    <= cfg_data[DIR_W-1:0];
				REG_DET_THRESHOLD: thr_q       <= cfg_data[THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// A stage loads when it is empty or the stage after it loads too.
	// The last stage loads when its result is taken or it holds nothing.
	always_comb begin
		stage_en[NSTAGE] = !vld_q[NSTAGE] || out_ready;
		for (int k = NSTAGE - 1; k >= 1; k--) begin
			stage_en[k] = !vld_q[k] || stage_en[k + 1];
		end
		vld_in = {vld_q[NSTAGE-1:1], in_valid};
	end

	// Advance the valid flags alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NSTAGE; k++) begin
				if (stage_en[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	assign in_ready  = stage_en[1];
	assign out_valid = vld_q[NSTAGE];
	assign hit       = hit_s8;

	assign va[0] = vertex_a_x;
	assign va[1] = vertex_a_y;
	assign va[2] = vertex_a_z;
	assign vb[0] = vertex_b_x;
	assign vb[1] = vertex_b_y;
	assign vb[2] = vertex_b_z;
	assign vc[0] = vertex_c_x;
	assign vc[1] = vertex_c_y;
	assign vc[2] = vertex_c_z;

	rti_edge u_edge (
		.clk   (clk),
		.en    (stage_en[1]),
		.va    (va),
		.vb    (vb),
		.vc    (vc),
		.org   (origin_q),
		.e1_s1 (e1_s1),
		.e2_s1 (e2_s1),
		.s_s1  (s_s1)
	);

	rti_cross u_cross (
		.clk   (clk),
		.en    (stage_en[3:2]),
		.d     (dir_q),
		.e1_s1 (e1_s1),
		.e2_s1 (e2_s1),
		.s_s1  (s_s1),
		.e1_s3 (e1_s3),
		.e2_s3 (e2_s3),
		.s_s3  (s_s3),
		.h_s3  (h_s3),
		.q_s3  (q_s3)
	);

	rti_dot u_dot (
		.clk    (clk),
		.en     (stage_en[6:4]),
		.d      (dir_q),
		.e1_s3  (e1_s3),
		.e2_s3  (e2_s3),
		.s_s3   (s_s3),
		.h_s3   (h_s3),
		.q_s3   (q_s3),
		.det_s6 (det_s6),
		.un_s6  (un_s6),
		.vn_s6  (vn_s6),
		.tn_s6  (tn_s6)
	);

	rti_test u_test (
		.clk    (clk),
		.en     (stage_en[8:7]),
		.thr    (thr_q),
		.det_s6 (det_s6),
		.un_s6  (un_s6),
		.vn_s6  (vn_s6),
		.tn_s6  (tn_s6),
		.hit_s8 (hit_s8)
	);

	// A taken result frees the whole chain, so a beat can always enter
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output is being taken");

	// A full stage 7 that advances must show up as a result
	a_last_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[NSTAGE-1] && stage_en[NSTAGE]) |=> out_valid)
		else $error("beat lost entering the output stage");

	// A threshold write lands in the register
	a_thr_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index == REG_DET_THRESHOLD) |=> thr_q == $past(cfg_data[THR_W-1:0]))
		else $error("det_threshold write not taken");

endmodule

### hw/rtl/rti_edge.sv
module rti_edge (
	input  logic           clk,
	input  logic           en,
	input  rti_pkg::coord_t va  [3],
	input  rti_pkg::coord_t vb  [3],
	input  rti_pkg::coord_t vc  [3],
	input  rti_pkg::coord_t org [3],
	output rti_pkg::edge_t  e1_s1 [3],
	output rti_pkg::edge_t  e2_s1 [3],
	output rti_pkg::edge_t  s_s1  [3]
);
	import rti_pkg::*;

	// Form both edges and the origin offset, one bit wider than a coordinate
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= EW'(vb[i]) - EW'(va[i]);
				e2_s1[i] <= EW'(vc[i]) - EW'(va[i]);
				s_s1[i]  <= EW'(org[i]) - EW'(va[i]);
			end
		end
	end

endmodule

### hw/rtl/rti_cross.sv
module rti_cross (
	input  logic          clk,
	input  logic [1:0]    en,
	input  rti_pkg::dir_t  d     [3],
	input  rti_pkg::edge_t e1_s1 [3],
	input  rti_pkg::edge_t e2_s1 [3],
	input  rti_pkg::edge_t s_s1  [3],
	output rti_pkg::edge_t e1_s3 [3],
	output rti_pkg::edge_t e2_s3 [3],
	output rti_pkg::edge_t s_s3  [3],
	output rti_pkg::h_t    h_s3  [3],
	output rti_pkg::q_t    q_s3  [3]
);
	import rti_pkg::*;

	hprod_t hpa_s2 [3];
	hprod_t hpb_s2 [3];
	qprod_t qpa_s2 [3];
	qprod_t qpb_s2 [3];
	edge_t  e1_s2  [3];
	edge_t  e2_s2  [3];
	edge_t  s_s2   [3];

	// Stage 2: the twelve cross-product terms, h = d x e2 and q = s x e1
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				hpa_s2[i] <= HP_W'(d[(i + 1) % 3]) * HP_W'(e2_s1[(i + 2) % 3]);
				hpb_s2[i] <= HP_W'(d[(i + 2) % 3]) * HP_W'(e2_s1[(i + 1) % 3]);
				qpa_s2[i] <= QP_W'(s_s1[(i + 1) % 3]) * QP_W'(e1_s1[(i + 2) % 3]);
				qpb_s2[i] <= QP_W'(s_s1[(i + 2) % 3]) * QP_W'(e1_s1[(i + 1) % 3]);
				e1_s2[i]  <= e1_s1[i];
				e2_s2[i]  <= e2_s1[i];
				s_s2[i]   <= s_s1[i];
			end
		end
	end

	// Stage 3: take the differences
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				h_s3[i]  <= H_W'(hpa_s2[i]) - H_W'(hpb_s2[i]);
				q_s3[i]  <= Q_W'(qpa_s2[i]) - Q_W'(qpb_s2[i]);
				e1_s3[i] <= e1_s2[i];
				e2_s3[i] <= e2_s2[i];
				s_s3[i]  <= s_s2[i];
			end
		end
	end

endmodule

### hw/rtl/rti_dot.sv
module rti_dot (
	input  logic          clk,
	input  logic [2:0]    en,
	input  rti_pkg::dir_t  d     [3],
	input  rti_pkg::edge_t e1_s3 [3],
	input  rti_pkg::edge_t e2_s3 [3],
	input  rti_pkg::edge_t s_s3  [3],
	input  rti_pkg::h_t    h_s3  [3],
	input  rti_pkg::q_t    q_s3  [3],
	output rti_pkg::dot_t  det_s6,
	output rti_pkg::dot_t  un_s6,
	output rti_pkg::dot_t  vn_s6,
	output rti_pkg::tn_t   tn_s6
);
	import rti_pkg::*;

	logic        [HL-1:0]     h_lo [3];
	logic signed [H_W-HL-1:0] h_hi [3];
	logic        [QL-1:0]     q_lo [3];
	logic signed [Q_W-QL-1:0] q_hi [3];

	logic signed [DLO_W-1:0] det_lo_s4 [3];
	logic signed [DHI_W-1:0] det_hi_s4 [3];
	logic signed [DLO_W-1:0] un_lo_s4  [3];
	logic signed [DHI_W-1:0] un_hi_s4  [3];
	logic signed [VLO_W-1:0] vn_lo_s4  [3];
	logic signed [VHI_W-1:0] vn_hi_s4  [3];
	logic signed [TLO_W-1:0] tn_lo_s4  [3];
	logic signed [THI_W-1:0] tn_hi_s4  [3];

	dot_t det_t_s5 [3];
	dot_t un_t_s5  [3];
	dot_t vn_t_s5  [3];
	tn_t  tn_t_s5  [3];

	// Split h and q: low half unsigned, high half signed
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			h_lo[i] = h_s3[i][HL-1:0];
			h_hi[i] = h_s3[i][H_W-1:HL];
			q_lo[i] = q_s3[i][QL-1:0];
			q_hi[i] = q_s3[i][Q_W-1:QL];
		end
	end

	// Stage 4: half-width partial products
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				det_lo_s4[i] <= DLO_W'(e1_s3[i]) * DLO_W'($signed({1'b0, h_lo[i]}));
				det_hi_s4[i] <= DHI_W'(e1_s3[i]) * DHI_W'(h_hi[i]);
				un_lo_s4[i]  <= DLO_W'(s_s3[i]) * DLO_W'($signed({1'b0, h_lo[i]}));
				un_hi_s4[i]  <= DHI_W'(s_s3[i]) * DHI_W'(h_hi[i]);
				vn_lo_s4[i]  <= VLO_W'(d[i]) * VLO_W'($signed({1'b0, q_lo[i]}));
				vn_hi_s4[i]  <= VHI_W'(d[i]) * VHI_W'(q_hi[i]);
				tn_lo_s4[i]  <= TLO_W'(e2_s3[i]) * TLO_W'($signed({1'b0, q_lo[i]}));
				tn_hi_s4[i]  <= THI_W'(e2_s3[i]) * THI_W'(q_hi[i]);
			end
		end
	end

	// Stage 5: rejoin each term
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				det_t_s5[i] <= (DOT_W'(det_hi_s4[i]) <<< HL) + DOT_W'(det_lo_s4[i]);
				un_t_s5[i]  <= (DOT_W'(un_hi_s4[i]) <<< HL) + DOT_W'(un_lo_s4[i]);
				vn_t_s5[i]  <= (DOT_W'(vn_hi_s4[i]) <<< QL) + DOT_W'(vn_lo_s4[i]);
				tn_t_s5[i]  <= (TN_W'(tn_hi_s4[i]) <<< QL) + TN_W'(tn_lo_s4[i]);
			end
		end
	end

	// Stage 6: sum the three terms of each dot product
	always_ff @(posedge clk) begin
		if (en[2]) begin
			det_s6 <= det_t_s5[0] + det_t_s5[1] + det_t_s5[2];
			un_s6  <= un_t_s5[0] + un_t_s5[1] + un_t_s5[2];
			vn_s6  <= vn_t_s5[0] + vn_t_s5[1] + vn_t_s5[2];
			tn_s6  <= tn_t_s5[0] + tn_t_s5[1] + tn_t_s5[2];
		end
	end

endmodule

### hw/rtl/rti_test.sv
module rti_test (
	input  logic         clk,
	input  logic [1:0]   en,
	input  rti_pkg::thr_t thr,
	input  rti_pkg::dot_t det_s6,
	input  rti_pkg::dot_t un_s6,
	input  rti_pkg::dot_t vn_s6,
	input  rti_pkg::tn_t  tn_s6,
	output logic         hit_s8
);
	import rti_pkg::*;

	dot_t det_s7;
	dot_t un_s7;
	dot_t vn_s7;
	tn_t  tn_s7;

	logic signed [DOT_W:0] uv_sum;
	logic                  thr_ok;

	// Stage 7: fold the sign of det into det and the three numerators
	always_ff @(posedge clk) begin
		if (en[0]) begin
			if (det_s6[DOT_W-1]) begin
				det_s7 <= -det_s6;
				un_s7  <= -un_s6;
				vn_s7  <= -vn_s6;
				tn_s7  <= -tn_s6;
			end else begin
				det_s7 <= det_s6;
				un_s7  <= un_s6;
				vn_s7  <= vn_s6;
				tn_s7  <= tn_s6;
			end
		end
	end

	// det is non-negative here, so an unsigned compare with the threshold holds
	always_comb begin
		uv_sum = (DOT_W + 1)'(un_s7) + (DOT_W + 1)'(vn_s7);
		thr_ok = ($unsigned(det_s7) >= DOT_W'(thr));
	end

	// Stage 8: bounds tests, result register; the distance compare is signed
	always_ff @(posedge clk) begin
		if (en[1]) begin
			hit_s8 <= (det_s7 != '0) && thr_ok
				&& !un_s7[DOT_W-1] && !vn_s7[DOT_W-1]
				&& (un_s7 <= det_s7)
				&& (uv_sum <= (DOT_W + 1)'(det_s7))
				&& (tn_s7 > TN_W'(0));
		end
	end

endmodule
